@@ rtl/core/i2cwm_pkg.sv @@
`default_nettype none
package i2cwm_pkg;

	localparam int unsigned ReqW   = 2;
	localparam int unsigned ByteW  = 8;
	localparam int unsigned HoldW  = 2;
	localparam int unsigned PhaseW = 5;
	localparam int unsigned AddrW  = 3;
	localparam int unsigned DataW  = 32;

	typedef enum logic [ReqW-1:0] {
		REQ_START = 2'd0,
		REQ_SEND  = 2'd1,
		REQ_STOP  = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	localparam logic [ByteW-1:0] DEV_ADDR_RESET = 8'd120;

	localparam logic [AddrW-1:0] REG_DEV_ADDR = 3'd0;

	// final phase index per command
	localparam logic [PhaseW-1:0] START_LAST = 5'd20;
	localparam logic [PhaseW-1:0] SEND_LAST  = 5'd17;
	localparam logic [PhaseW-1:0] STOP_LAST  = 5'd2;

	// first address bit phase of a start
	localparam logic [PhaseW-1:0] START_BITS = 5'd3;

	localparam logic [HoldW-1:0] HOLD_SHORT = 2'd1;
	localparam logic [HoldW-1:0] HOLD_LONG  = 2'd2;

	typedef struct packed {
		logic             scl;
		logic             sda;
		logic [HoldW-1:0] hold;
		logic             last;
	} phase_t;

endpackage
`default_nettype wire

@@ rtl/core/i2c_write_master_phases.sv @@
// Write-only I2C master phase generator.
// The first phase of an item is decoded from the registered command, then registered into the output stage.
// Throughput: one phase per cycle while phase_stall is low; a start emits 21 phases, a send 18,
// a stop 3 and an unused code none, as set by the phase counter of the generator stage.
// The next item is accepted in the cycle its predecessor's last phase is registered.
// Reset (arst_n low, asynchronous) clears the pipeline and sets the address byte to 120.
`default_nettype none
module i2c_write_master_phases (
	input  wire                             clk,
	input  wire                             arst_n,
	// APB-style configuration port
	input  wire                             psel,
	input  wire                             penable,
	input  wire                             pwrite,
	input  wire  [i2cwm_pkg::AddrW-1:0]     paddr,
	input  wire  [i2cwm_pkg::DataW-1:0]     pwdata,
	output logic [i2cwm_pkg::DataW-1:0]     prdata,
	output logic                            pready,
	// command channel
	input  wire                             req_valid,
	output logic                            req_stall,
	input  wire  [i2cwm_pkg::ReqW-1:0]      req_type,
	input  wire  [i2cwm_pkg::ByteW-1:0]     data_byte,
	// phase channel
	output logic                            phase_valid,
	input  wire                             phase_stall,
	output logic                            scl_level,
	output logic                            sda_level,
	output logic [i2cwm_pkg::HoldW-1:0]     hold_units,
	output logic                            last_phase
);
	import i2cwm_pkg::*;

	logic [ByteW-1:0]  dev_addr_q;
	logic              busy_q;
	req_t              req_s1;
	logic [ByteW-1:0]  byte_s1;
	logic [PhaseW-1:0] idx_q;
	logic              out_valid_q;
	phase_t            out_q;

	logic              cfg_wr;
	logic              out_load;
	logic              gen_adv;
	logic              req_acc;
	phase_t            ph;
	logic [PhaseW-1:0] bit_pos;
	logic [2:0]        bit_sel;
	logic              cur_bit;
	req_t              req_in;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		prdata = '0;
		if (paddr[AddrW-1:2] == REG_DEV_ADDR[AddrW-1:2]) begin
			prdata = {{(DataW-ByteW){1'b0}}, dev_addr_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= DEV_ADDR_RESET;
		end else if (cfg_wr && paddr[AddrW-1:2] == REG_DEV_ADDR[AddrW-1:2]) begin
			dev_addr_q <= pwdata[ByteW-1:0];
		end
	end

	// phase decode
	always_comb begin
		bit_pos = (req_s1 == REQ_START) ? idx_q - START_BITS : idx_q;
		bit_sel = 3'd7 - bit_pos[3:1];
		cur_bit = byte_s1[bit_sel];
		ph      = '{scl: 1'b1, sda: 1'b1, hold: HOLD_SHORT, last: 1'b0};
		case (req_s1)
			REQ_START: begin
				if (idx_q < START_BITS) begin
					ph.hold = HOLD_LONG;
					ph.scl  = (idx_q != 5'd2);
					ph.sda  = (idx_q == 5'd0);
				end else if (idx_q < START_LAST - 5'd1) begin
					ph.scl = ~bit_pos[0];
					ph.sda = cur_bit;
				end else begin
					ph.scl  = (idx_q != START_LAST);
					ph.last = (idx_q == START_LAST);
				end
			end
			REQ_SEND: begin
				if (idx_q < SEND_LAST - 5'd1) begin
					ph.scl = bit_pos[0];
					ph.sda = cur_bit;
				end else begin
					ph.scl  = (idx_q == SEND_LAST);
					ph.last = (idx_q == SEND_LAST);
				end
			end
			REQ_STOP: begin
				ph.hold = HOLD_LONG;
				ph.scl  = (idx_q != 5'd0);
				ph.sda  = (idx_q == STOP_LAST);
				ph.last = (idx_q == STOP_LAST);
			end
			default: begin
				ph.last = 1'b1;
			end
		endcase
	end

	assign out_load  = !out_valid_q || !phase_stall;
	assign gen_adv   = busy_q && out_load;
	assign req_stall = busy_q && !(gen_adv && ph.last);
	assign req_acc   = req_valid && !req_stall;
	assign req_in    = req_t'(req_type);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
			req_s1 <= REQ_NONE;
		end else if (req_acc) begin
			busy_q <= (req_in != REQ_NONE);
			idx_q  <= '0;
			req_s1 <= req_in;
		end else if (gen_adv) begin
			busy_q <= !ph.last;
			idx_q  <= idx_q + 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			byte_s1 <= (req_in == REQ_START) ? dev_addr_q : data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (gen_adv) begin
			out_q <= ph;
		end
	end

	assign phase_valid = out_valid_q;
	assign scl_level   = out_q.scl;
	assign sda_level   = out_q.sda;
	assign hold_units  = out_q.hold;
	assign last_phase  = out_q.last;

	// a new item enters a busy generator only as its last phase leaves
	a_overlap_only_at_last: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && busy_q |-> gen_adv && ph.last)
		else $error("item accepted mid-command");

	// phase counter stays within the command's length
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (req_s1 == REQ_START && idx_q <= START_LAST)
			|| (req_s1 == REQ_SEND && idx_q <= SEND_LAST)
			|| (req_s1 == REQ_STOP && idx_q <= STOP_LAST))
		else $error("phase counter out of range");

	// an idle generator never holds off commands
	a_idle_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> !req_stall)
		else $error("stall while idle");

endmodule
`default_nettype wire

@@ tb/tb.sv @@
module tb;
	import i2cwm_pkg::*;

	typedef struct {
		req_t             kind;
		logic [ByteW-1:0] data;
	} cmd_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic             psel = 1'b0;
	logic             penable = 1'b0;
	logic             pwrite = 1'b0;
	logic [AddrW-1:0] paddr = '0;
	logic [DataW-1:0] pwdata = '0;
	logic [DataW-1:0] prdata;
	logic             pready;

	logic             req_valid = 1'b0;
	logic             req_stall;
	logic [ReqW-1:0]  req_type = REQ_NONE;
	logic [ByteW-1:0] data_byte = '0;

	logic             phase_valid;
	logic             phase_stall = 1'b0;
	logic             scl_level;
	logic             sda_level;
	logic [HoldW-1:0] hold_units;
	logic             last_phase;

	cmd_item_t        cmd_q[$];
	phase_t           phase_exp_q[$];
	logic [ByteW-1:0] dev_addr_cfg = DEV_ADDR_RESET;

	logic cmd_taken = 1'b0;
	logic phase_taken = 1'b0;
	int   cmd_gap = 0;
	int   sink_wait = 0;
	int   src_gap_max = 0;
	int   sink_max = 0;
	int   freeze_asked = 0;
	int   freeze_served = 0;
	int   freeze_left = 0;
	int   err_cnt = 0;
	int   n_rand = 0;

	i2c_write_master_phases dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_type(req_type),
		.data_byte(data_byte),
		.phase_valid(phase_valid),
		.phase_stall(phase_stall),
		.scl_level(scl_level),
		.sda_level(sda_level),
		.hold_units(hold_units),
		.last_phase(last_phase)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic report_err(input string msg);
		if (err_cnt < 40) begin
			$display("MISMATCH @%0t: %s", $realtime, msg);
		end
		err_cnt++;
	endtask

	function automatic phase_t mk_phase(input logic scl, input logic sda,
			input logic [HoldW-1:0] hold);
		phase_t p;
		p.scl  = scl;
		p.sda  = sda;
		p.hold = hold;
		p.last = 1'b0;
		return p;
	endfunction

	// line phases caused by one command, appended to the expected stream
	task automatic queue_phases(input req_t kind, input logic [ByteW-1:0] data);
		phase_t seq[$];
		phase_t tail;
		case (kind)
		REQ_START: begin
			seq.push_back(mk_phase(1'b1, 1'b1, HOLD_LONG));
			seq.push_back(mk_phase(1'b1, 1'b0, HOLD_LONG));
			seq.push_back(mk_phase(1'b0, 1'b0, HOLD_LONG));
			for (int i = ByteW - 1; i >= 0; i--) begin
				seq.push_back(mk_phase(1'b1, dev_addr_cfg[i], HOLD_SHORT));
				seq.push_back(mk_phase(1'b0, dev_addr_cfg[i], HOLD_SHORT));
			end
			seq.push_back(mk_phase(1'b1, 1'b1, HOLD_SHORT));
			seq.push_back(mk_phase(1'b0, 1'b1, HOLD_SHORT));
		end
		REQ_SEND: begin
			for (int i = ByteW - 1; i >= 0; i--) begin
				seq.push_back(mk_phase(1'b0, data[i], HOLD_SHORT));
				seq.push_back(mk_phase(1'b1, data[i], HOLD_SHORT));
			end
			seq.push_back(mk_phase(1'b0, 1'b1, HOLD_SHORT));
			seq.push_back(mk_phase(1'b1, 1'b1, HOLD_SHORT));
		end
		REQ_STOP: begin
			seq.push_back(mk_phase(1'b0, 1'b0, HOLD_LONG));
			seq.push_back(mk_phase(1'b1, 1'b0, HOLD_LONG));
			seq.push_back(mk_phase(1'b1, 1'b1, HOLD_LONG));
		end
		default: begin
		end
		endcase
		if (seq.size() > 0) begin
			tail = seq.pop_back();
			tail.last = 1'b1;
			seq.push_back(tail);
			foreach (seq[i]) phase_exp_q.push_back(seq[i]);
		end
	endtask

	// monitor: checks phases and predicts from accepted commands
	always @(posedge clk) begin
		phase_t want;
		cmd_taken   <= arst_n && req_valid && !req_stall;
		phase_taken <= arst_n && phase_valid && !phase_stall;
		if (arst_n && phase_valid && !phase_stall) begin
			if (phase_exp_q.size() == 0) begin
				report_err($sformatf("phase with none pending: scl=%0b sda=%0b hold=%0d last=%0b",
					scl_level, sda_level, hold_units, last_phase));
			end else begin
				want = phase_exp_q.pop_front();
				if (scl_level !== want.scl)
					report_err($sformatf("scl_level %0b, want %0b", scl_level, want.scl));
				if (sda_level !== want.sda)
					report_err($sformatf("sda_level %0b, want %0b", sda_level, want.sda));
				if (hold_units !== want.hold)
					report_err($sformatf("hold_units %0d, want %0d", hold_units, want.hold));
				if (last_phase !== want.last)
					report_err($sformatf("last_phase %0b, want %0b", last_phase, want.last));
			end
		end
		if (arst_n && req_valid && !req_stall)
			queue_phases(req_t'(req_type), data_byte);
	end

	// command driver
	always @(negedge clk) begin
		cmd_item_t c;
		logic      nv;
		nv = req_valid && !cmd_taken;
		if (arst_n && !nv) begin
			if (cmd_gap > 0) begin
				cmd_gap--;
			end else if (cmd_q.size() > 0) begin
				c = cmd_q.pop_front();
				req_type  <= c.kind;
				data_byte <= c.data;
				nv = 1'b1;
				cmd_gap = $urandom_range(0, src_gap_max);
			end
		end
		req_valid <= nv;
	end

	// phase receiver: per-item wait, plus an occasional long freeze
	always @(negedge clk) begin
		logic ns;
		if (freeze_served != freeze_asked) begin
			freeze_served++;
			freeze_left = 150;
		end
		if (phase_taken)
			sink_wait = $urandom_range(0, sink_max);
		if (freeze_left > 0) begin
			freeze_left--;
			ns = 1'b1;
		end else if (sink_wait > 0) begin
			sink_wait--;
			ns = 1'b1;
		end else begin
			ns = 1'b0;
		end
		phase_stall <= ns;
	end

	task automatic push_cmd(input req_t kind, input logic [ByteW-1:0] data);
		cmd_item_t c;
		c.kind = kind;
		c.data = data;
		cmd_q.push_back(c);
		if (kind != REQ_NONE)
			n_rand++;
	endtask

	task automatic wait_drained();
		do @(posedge clk);
		while (cmd_q.size() != 0 || req_valid || phase_exp_q.size() != 0);
		// then let the bench sit idle before the caller moves on
		repeat (4) @(posedge clk);
	endtask

	task automatic write_dev_addr(input logic [DataW-1:0] wdata);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= REG_DEV_ADDR;
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk);
		while (!pready);
		dev_addr_cfg = wdata[ByteW-1:0];
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk);
		while (!pready);
		if (prdata[ByteW-1:0] !== dev_addr_cfg)
			report_err($sformatf("address byte reads %0h, want %0h",
				prdata[ByteW-1:0], dev_addr_cfg));
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// mostly start / data bytes / stop, sometimes stray or unused commands
	task automatic push_transaction();
		int n;
		if ($urandom_range(0, 99) < 85) begin
			push_cmd(REQ_START, ByteW'($urandom_range(0, 255)));
			n = $urandom_range(0, 4);
			repeat (n) push_cmd(REQ_SEND, ByteW'($urandom_range(0, 255)));
			push_cmd(REQ_STOP, ByteW'($urandom_range(0, 255)));
		end else begin
			n = $urandom_range(1, 3);
			repeat (n) push_cmd(req_t'(ReqW'($urandom_range(0, 3))),
				ByteW'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		logic [ByteW-1:0] val;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset address byte, back to back
		push_cmd(REQ_START, 8'hFF);
		push_cmd(REQ_SEND, 8'h00);
		push_cmd(REQ_SEND, 8'hFF);
		push_cmd(REQ_SEND, 8'hA5);
		push_cmd(REQ_SEND, 8'h5A);
		push_cmd(REQ_STOP, 8'hFF);
		push_cmd(REQ_NONE, 8'hFF);
		push_cmd(REQ_NONE, 8'h00);
		push_cmd(REQ_START, 8'h00);
		push_cmd(REQ_SEND, 8'h80);
		push_cmd(REQ_SEND, 8'h01);
		push_cmd(REQ_STOP, 8'h00);
		wait_drained();

		src_gap_max = 4;
		sink_max = 4;
		write_dev_addr('0);
		push_cmd(REQ_START, 8'h00);
		push_cmd(REQ_SEND, 8'h7F);
		push_cmd(REQ_STOP, 8'h00);
		wait_drained();
		write_dev_addr('1);
		push_cmd(REQ_START, 8'hFF);
		push_cmd(REQ_SEND, 8'hFE);
		push_cmd(REQ_STOP, 8'hFF);

		n_rand = 0;
		for (int r = 0; n_rand < 310; r++) begin
			wait_drained();
			case (r % 4)
			0: val = 8'h00;
			1: val = 8'hFF;
			default: val = ByteW'($urandom_range(0, 255));
			endcase
			write_dev_addr({(DataW-ByteW)'($urandom()), val});
			src_gap_max = (r % 3 == 0) ? 0 : 4;
			sink_max = (r % 3 == 1) ? 0 : 4;
			if (r == 1 || r == 6)
				freeze_asked++;
			repeat ($urandom_range(2, 5)) push_transaction();
		end

		wait_drained();
		repeat (25) @(posedge clk);
		if (err_cnt == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

	initial begin
		#3_200_000;
		$display("tb: errors");
		$finish;
	end

endmodule

@@ i2c_write_master_phases.f @@
rtl/core/i2cwm_pkg.sv
rtl/core/i2c_write_master_phases.sv
tb/tb.sv
